// ----- hw/rtl/dmre_pkg.sv -----
// dmre_pkg: shared types and codes for the distributed mutex request engine
// no dependencies
`default_nettype none
package dmre_pkg;

  // fixed sizes of the engine
  localparam int MAX_PROCESSES  = 16;
  localparam int MAX_HOUSES     = 64;
  localparam int TIMESTAMP_BITS = 32;

  typedef enum logic [3:0] {
    FN_REQ_HOUSE   = 4'd0,
    FN_REQ_PASER   = 4'd1,
    FN_PEER_HOUSE  = 4'd2,
    FN_PEER_PASER  = 4'd3,
    FN_REPLY_HOUSE = 4'd4,
    FN_REPLY_PASER = 4'd5,
    FN_GOT_HOUSE   = 4'd6,
    FN_FREE_HOUSE  = 4'd7,
    FN_GOT_PASER   = 4'd8,
    FN_FREE_PASER  = 4'd9
  } func_t;

  localparam logic [2:0] SK_NONE        = 3'd0;
  localparam logic [2:0] SK_BCAST_HOUSE = 3'd1;
  localparam logic [2:0] SK_BCAST_PASER = 3'd2;
  localparam logic [2:0] SK_REPLY_HOUSE = 3'd3;
  localparam logic [2:0] SK_REPLY_PASER = 3'd4;
  localparam logic [2:0] SK_UPDATE      = 3'd5;

  localparam logic [1:0] CFG_SELF_ID       = 2'd0;
  localparam logic [1:0] CFG_PROCESS_COUNT = 2'd1;
  localparam logic [1:0] CFG_PASER_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN,
    ST_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic exec;       // apply the event, build the first result word
    logic drain;      // build the next deferred reply word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;       // further drain words follow the current one
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dmre_ram.sv -----
// dmre_ram: generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module dmre_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dmre_ctrl.sv -----
// dmre_ctrl: sequencing controller for the request engine
// depends on dmre_pkg
`default_nettype none
module dmre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dmre_pkg::cmd_t         cmd,
  input  wire dmre_pkg::status_t status
);

  dmre_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dmre_pkg::ST_IDLE: begin
        if (in_valid) state_next = dmre_pkg::ST_EXEC;
      end
      dmre_pkg::ST_EXEC: begin
        state_next = dmre_pkg::ST_WAIT;
      end
      dmre_pkg::ST_DRAIN: begin
        state_next = dmre_pkg::ST_WAIT;
      end
      dmre_pkg::ST_WAIT: begin
        if (!out_stall) begin
          state_next = status.more ? dmre_pkg::ST_DRAIN : dmre_pkg::ST_IDLE;
        end
      end
      default: state_next = dmre_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      dmre_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      dmre_pkg::ST_EXEC:  cmd.exec = 1'b1;
      dmre_pkg::ST_DRAIN: cmd.drain = 1'b1;
      dmre_pkg::ST_WAIT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dmre_dp.sv -----
// dmre_dp: protocol state, deferred queues and result word for the engine
// depends on dmre_pkg and dmre_ram
`default_nettype none
module dmre_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dmre_pkg::cmd_t    cmd,
  output dmre_pkg::status_t      status,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [4:0]        cfg_data,
  input  wire logic [3:0]        func,
  input  wire logic [4:0]        sender,
  input  wire logic [31:0]       msg_timestamp,
  input  wire logic [31:0]       now,
  input  wire logic [6:0]        acq_house,
  output logic [2:0]             send_kind,
  output logic [4:0]             send_target,
  output logic [31:0]            send_timestamp,
  output logic [6:0]             update_house,
  output logic [4:0]             update_owner,
  output logic                   house_ready,
  output logic                   paser_ready,
  output logic                   house_held,
  output logic [6:0]             held_house,
  output logic                   paser_held,
  output logic                   last
);

  localparam int PW = $clog2(dmre_pkg::MAX_PROCESSES);
  localparam int CW = $clog2(dmre_pkg::MAX_PROCESSES + 1);
  localparam int TW = dmre_pkg::TIMESTAMP_BITS;

  // configuration
  logic [4:0] self_id, process_count, paser_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id       <= 5'd1;
      process_count <= 5'd2;
      paser_count   <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dmre_pkg::CFG_SELF_ID:       self_id <= cfg_data;
        dmre_pkg::CFG_PROCESS_COUNT: process_count <= cfg_data;
        dmre_pkg::CFG_PASER_COUNT:   paser_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic [3:0]    r_func;
  logic [4:0]    r_sender;
  logic [TW-1:0] r_ts, r_now;
  logic [6:0]    r_hid;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func   <= func;
      r_sender <= sender;
      r_ts     <= msg_timestamp[TW-1:0];
      r_now    <= now[TW-1:0];
      r_hid    <= acq_house;
    end
  end

  // protocol state
  logic                               h_req, p_req, p_hold;
  logic [TW-1:0]                      h_time, p_time;
  logic [6:0]                         held;
  logic [dmre_pkg::MAX_PROCESSES-1:0] h_miss, p_miss;
  logic [CW-1:0]                      h_cnt, p_cnt;

  // drain sequencing: index of the next queued reply and number of replies
  logic          drain_paser;
  logic [CW-1:0] drain_idx, drain_len;
  logic [TW-1:0] drain_now;

  // peer mask over configured processes
  logic [dmre_pkg::MAX_PROCESSES-1:0] pmask;
  always_comb begin
    for (int i = 0; i < dmre_pkg::MAX_PROCESSES; i++) begin
      pmask[i] = ((i + 1) <= int'(process_count)) && ((i + 1) != int'(self_id));
    end
  end

  logic [dmre_pkg::MAX_PROCESSES-1:0] sbit;
  always_comb begin
    sbit = '0;
    if (r_sender >= 5'd1 && int'(r_sender) <= dmre_pkg::MAX_PROCESSES) begin
      sbit[PW'(r_sender - 5'd1)] = 1'b1;
    end
  end

  // priority decisions
  logic h_answer, p_answer;
  always_comb begin
    h_answer = (held == 7'd0) && (!h_req || r_ts < h_time ||
               (r_ts == h_time && r_sender < self_id));
    h_answer = h_answer || (int'(h_cnt) >= dmre_pkg::MAX_PROCESSES);
    p_answer = !p_hold && (!p_req || r_ts < p_time ||
               (r_ts == p_time && r_sender < self_id));
    p_answer = p_answer || (int'(p_cnt) >= dmre_pkg::MAX_PROCESSES);
  end

  // deferred queues
  logic          h_we, p_we;
  logic [PW-1:0] rd_addr;
  logic [4:0]    h_rdata, p_rdata;
  assign h_we = cmd.exec && r_func == dmre_pkg::FN_PEER_HOUSE && !h_answer;
  assign p_we = cmd.exec && r_func == dmre_pkg::FN_PEER_PASER && !p_answer;

  // entry zero is read while a word is taken, so a paser release has it in exec
  assign rd_addr = cmd.load ? '0 : drain_idx[PW-1:0];

  dmre_ram #(.WIDTH(5), .DEPTH(dmre_pkg::MAX_PROCESSES)) u_hram (
    .clk(clk), .we(h_we), .waddr(h_cnt[PW-1:0]), .wdata(r_sender),
    .raddr(rd_addr), .rdata(h_rdata)
  );
  dmre_ram #(.WIDTH(5), .DEPTH(dmre_pkg::MAX_PROCESSES)) u_pram (
    .clk(clk), .we(p_we), .waddr(p_cnt[PW-1:0]), .wdata(r_sender),
    .raddr(rd_addr), .rdata(p_rdata)
  );

  // event handling and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      h_req <= 1'b0; p_req <= 1'b0; p_hold <= 1'b0;
      h_time <= '0; p_time <= '0; held <= '0;
      h_miss <= '0; p_miss <= '0; h_cnt <= '0; p_cnt <= '0;
      drain_len <= '0; drain_idx <= '0; drain_paser <= 1'b0;
    end else if (cmd.exec) begin
      send_kind      <= dmre_pkg::SK_NONE;
      send_target    <= '0;
      send_timestamp <= '0;
      update_house   <= '0;
      update_owner   <= '0;
      drain_len      <= '0;
      drain_idx      <= '0;
      drain_now      <= r_now;
      drain_paser    <= 1'b0;
      case (r_func)
        dmre_pkg::FN_REQ_HOUSE: begin
          h_req <= 1'b1; h_time <= r_now; h_miss <= pmask;
          send_kind <= dmre_pkg::SK_BCAST_HOUSE;
          send_timestamp <= 32'(r_now);
        end
        dmre_pkg::FN_REQ_PASER: begin
          p_req <= 1'b1; p_time <= r_now; p_miss <= pmask;
          send_kind <= dmre_pkg::SK_BCAST_PASER;
          send_timestamp <= 32'(r_now);
        end
        dmre_pkg::FN_PEER_HOUSE: begin
          if (h_answer) begin
            send_kind <= dmre_pkg::SK_REPLY_HOUSE;
            send_target <= r_sender; send_timestamp <= 32'(r_now);
          end else begin
            h_cnt <= h_cnt + CW'(1);
          end
        end
        dmre_pkg::FN_PEER_PASER: begin
          if (p_answer) begin
            send_kind <= dmre_pkg::SK_REPLY_PASER;
            send_target <= r_sender; send_timestamp <= 32'(r_now);
          end else begin
            p_cnt <= p_cnt + CW'(1);
          end
        end
        dmre_pkg::FN_REPLY_HOUSE: begin
          if (h_req && r_ts >= h_time) h_miss <= h_miss & ~sbit;
        end
        dmre_pkg::FN_REPLY_PASER: begin
          if (p_req && r_ts >= p_time) p_miss <= p_miss & ~sbit;
        end
        dmre_pkg::FN_GOT_HOUSE: begin
          if (r_hid >= 7'd1 && int'(r_hid) <= dmre_pkg::MAX_HOUSES) begin
            held <= r_hid; h_req <= 1'b0;
            send_kind <= dmre_pkg::SK_UPDATE;
            update_house <= r_hid; update_owner <= self_id;
          end
        end
        dmre_pkg::FN_FREE_HOUSE: begin
          if (held != 7'd0) begin
            held <= '0; h_req <= 1'b0;
            send_kind <= dmre_pkg::SK_UPDATE;
            update_house <= held;
            drain_len <= h_cnt;
            h_cnt <= '0;
          end
        end
        dmre_pkg::FN_GOT_PASER: begin
          p_hold <= 1'b1; p_req <= 1'b0;
        end
        dmre_pkg::FN_FREE_PASER: begin
          p_hold <= 1'b0; p_req <= 1'b0;
          p_cnt <= '0;
          drain_paser <= 1'b1;
          if (p_cnt != '0) begin
            // first deferred reply is the first word
            send_kind <= dmre_pkg::SK_REPLY_PASER;
            send_target <= p_rdata;
            send_timestamp <= 32'(r_now);
            drain_len <= p_cnt;
            drain_idx <= CW'(1);
          end
        end
        default: ;
      endcase
    end else if (cmd.drain) begin
      drain_idx      <= drain_idx + CW'(1);
      send_kind      <= drain_paser ? dmre_pkg::SK_REPLY_PASER : dmre_pkg::SK_REPLY_HOUSE;
      send_target    <= drain_paser ? p_rdata : h_rdata;
      send_timestamp <= 32'(drain_now);
      update_house   <= '0;
      update_owner   <= '0;
    end
  end

  // more replies remain while the next index is below the queue length
  always_comb begin
    status.more = drain_idx < drain_len;
  end

  // status outputs
  logic [CW-1:0] p_miss_cnt;
  always_comb begin
    p_miss_cnt = '0;
    for (int i = 0; i < dmre_pkg::MAX_PROCESSES; i++) begin
      p_miss_cnt = p_miss_cnt + CW'(p_miss[i]);
    end
  end

  assign house_ready = h_req && (h_miss == '0);
  assign paser_ready = (paser_count != 5'd0) && (32'(p_miss_cnt) < 32'(paser_count));
  assign house_held  = held != 7'd0;
  assign held_house  = held;
  assign paser_held  = p_hold;
  assign last        = !status.more;

endmodule
`default_nettype wire

// ----- hw/rtl/distributed_mutex_request_engine.sv -----
// distributed_mutex_request_engine: top level, controller plus datapath
// depends on dmre_pkg, dmre_ctrl, dmre_dp, dmre_ram
// An event is accepted, then applied, then its result word is offered and held
// until taken; a new word is accepted only after the last result word is taken.
// A release sends its deferred replies one word at a time, read in order from
// the deferred queue memory, each built in a drain step and offered until taken;
// a house release first offers its update word, a paser release its first
// deferred reply (an empty word if none is queued). Configuration is written
// through cfg_we/cfg_index/cfg_data while idle: the user's rule, not enforced.
`default_nettype none
module distributed_mutex_request_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  func,
  input  wire logic [4:0]  sender,
  input  wire logic [31:0] msg_timestamp,
  input  wire logic [31:0] now,
  input  wire logic [6:0]  acq_house,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       send_kind,
  output logic [4:0]       send_target,
  output logic [31:0]      send_timestamp,
  output logic [6:0]       update_house,
  output logic [4:0]       update_owner,
  output logic             house_ready,
  output logic             paser_ready,
  output logic             house_held,
  output logic [6:0]       held_house,
  output logic             paser_held,
  output logic             last
);

  dmre_pkg::cmd_t    cmd;
  dmre_pkg::status_t status;

  dmre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  dmre_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .sender(sender), .msg_timestamp(msg_timestamp), .now(now),
    .acq_house(acq_house), .send_kind(send_kind), .send_target(send_target),
    .send_timestamp(send_timestamp), .update_house(update_house),
    .update_owner(update_owner), .house_ready(house_ready),
    .paser_ready(paser_ready), .house_held(house_held), .held_house(held_house),
    .paser_held(paser_held), .last(last)
  );

endmodule
`default_nettype wire
